[sv/idcf_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the deadband correction filter.
package idcf_pkg;

	localparam int FILTER_ORDER_DEF = 4;

	localparam int SAMP_W   = 32;
	localparam int COEF_W   = 32;
	localparam int GAIN_W   = 32;
	localparam int MM_W     = 21;
	localparam int HIST_W   = 48;
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 32;

	// Partial-product multiplier: the 48-bit history operand is taken in two 24-bit halves.
	localparam int LO_W     = 24;
	localparam int MUL_A_W  = LO_W + 1;
	localparam int MUL_B_W  = COEF_W + 1;
	localparam int PP_W     = MUL_A_W + MUL_B_W;
	localparam int FULL_W   = HIST_W + MUL_B_W;

	localparam int GAIN_SHIFT = 30;
	localparam int COEF_SHIFT = 27;

	localparam logic signed [HIST_W-1:0] MAX48 = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic signed [HIST_W-1:0] MIN48 = {1'b1, {(HIST_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVE = 1'd1;

	localparam logic [GAIN_W-1:0] INV_GAIN_RST = 32'd1073741824;
	localparam logic [MM_W-1:0]   MIN_MOVE_RST = 21'd6554;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILTER  = 2'd0,
		CMD_LOAD_FF = 2'd1,
		CMD_LOAD_FB = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		A_UIN,
		A_IN_HIST,
		A_OUT_HIST,
		A_U
	} asel_t;

	typedef enum logic [1:0] {
		B_GAIN,
		B_FF,
		B_FB
	} bsel_t;

	typedef struct packed {
		logic  take;
		logic  ld_ff;
		logic  ld_fb;
		logic  clr;
		logic  load_uin;
		logic  mac_vld;
		logic  mac_hi;
		asel_t a_sel;
		bsel_t b_sel;
		logic  sum;
		logic  diff;
		logic  emit;
		logic  update;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t req_cmd;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

[sv/iir_deadband_correction_filter.sv]
// Top level of the deadband IIR guide correction filter: controller and datapath.
//
//   Channel   Direction  Handshake              Contents
//   request   in         in_valid / in_stall    command, coef_index, coef_value, sample
//   result    out        out_valid / out_stall  correction, suppressed
//   config    in         cfg_we                 cfg_index, cfg_data
//
// A filter request holds in_stall high until its result has been emitted and the correction
// sum updated; this includes any time the previous result still waits at the output.
// Its pace is set by the single shared 25x33 multiplier, which takes each 48-bit operand
// in two halves over 2*FILTER_ORDER + 2 products.
// Coefficient load and clear requests produce no result; in_stall is released after decode.
// Reset clears the coefficients, both histories and the correction sum at once.
// A stalled result stays in the output register while the next request is computed.
//
// A request is accepted while in_stall is low; the controller raises in_stall at once and
// releases it when the request completes. Every filter request first scales the
// uncorrected offset by the reciprocal gain, then accumulates the feed-forward taps on the
// old input history, the feedback taps on the old output history, and finally tap zero on
// the newly scaled input. The four-stage multiply pipeline (partial product, join and round
// bias, scale and saturate, accumulate) is drained before the filter output is formed.
module iir_deadband_correction_filter #(
	parameter int FILTER_ORDER = idcf_pkg::FILTER_ORDER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [idcf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [idcf_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [idcf_pkg::CMD_W-1:0]           command,
	input  logic [idcf_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [idcf_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [idcf_pkg::SAMP_W-1:0]   sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [idcf_pkg::SAMP_W-1:0]   correction,
	output logic                                 suppressed
);
	import idcf_pkg::*;

	localparam int TW = $clog2(FILTER_ORDER + 1);

	ctrl_cmd_t     cmd;
	dp_status_t    stat;
	logic [TW-1:0] tap;

	// The controller owns the request handshake and every sequencing decision.
	idcf_ctrl #(
		.FILTER_ORDER(FILTER_ORDER),
		.TW          (TW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd),
		.tap      (tap)
	);

	// The datapath holds all state of the filter and the result register.
	idcf_datapath #(
		.FILTER_ORDER(FILTER_ORDER),
		.TW          (TW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.tap        (tap),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.command    (command),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.sample     (sample),
		.out_stall  (out_stall),
		.stat       (stat),
		.out_valid  (out_valid),
		.correction (correction),
		.suppressed (suppressed)
	);

endmodule

[sv/idcf_datapath.sv]
// Datapath: request and coefficient registers, histories, shared multiply-accumulate and output stage.
module idcf_datapath #(
	parameter int FILTER_ORDER = idcf_pkg::FILTER_ORDER_DEF,
	parameter int TW = $clog2(FILTER_ORDER + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  idcf_pkg::ctrl_cmd_t                  cmd,
	input  logic [TW-1:0]                        tap,
	input  logic                                 cfg_we,
	input  logic [idcf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [idcf_pkg::CFG_W-1:0]           cfg_data,
	input  logic [idcf_pkg::CMD_W-1:0]           command,
	input  logic [idcf_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [idcf_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [idcf_pkg::SAMP_W-1:0]   sample,
	input  logic                                 out_stall,
	output idcf_pkg::dp_status_t                 stat,
	output logic                                 out_valid,
	output logic signed [idcf_pkg::SAMP_W-1:0]   correction,
	output logic                                 suppressed
);
	import idcf_pkg::*;

	localparam int NTAP  = FILTER_ORDER + 1;
	localparam int HW    = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
	localparam int IXW   = (TW > IDX_W) ? TW : IDX_W;
	localparam int ACC_W = HIST_W + $clog2(2 * FILTER_ORDER + 1);

	typedef struct packed {
		logic vld;
		logic hi;
		logic gain;
	} pipe_tag_t;

	// Configuration registers.
	logic [GAIN_W-1:0] inv_gain_q;
	logic [MM_W-1:0]   min_move_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_gain_q <= INV_GAIN_RST;
			min_move_q <= MIN_MOVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_GAIN: inv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_MIN_MOVE: min_move_q <= cfg_data[MM_W-1:0];
				default: ;
			endcase
		end
	end

	// Captured request.
	cmd_t                     req_cmd_q;
	logic [IDX_W-1:0]         req_idx_q;
	logic signed [COEF_W-1:0] req_coef_q;
	logic signed [SAMP_W-1:0] req_sample_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_cmd_q    <= cmd_t'(command);
			req_idx_q    <= coef_index;
			req_coef_q   <= coef_value;
			req_sample_q <= sample;
		end
	end

	// Coefficients. Feedback tap k (1..N) lives at fb_q[k-1].
	logic signed [COEF_W-1:0] ff_q [NTAP];
	logic signed [COEF_W-1:0] fb_q [FILTER_ORDER];
	logic [IXW-1:0]           idx_ext;
	logic                     idx_ok;

	assign idx_ext = IXW'(req_idx_q);
	assign idx_ok  = idx_ext <= IXW'(FILTER_ORDER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NTAP; k++) ff_q[k] <= '0;
			for (int k = 0; k < FILTER_ORDER; k++) fb_q[k] <= '0;
		end else begin
			if (cmd.ld_ff && idx_ok)
				ff_q[idx_ext[TW-1:0]] <= req_coef_q;
			if (cmd.ld_fb && idx_ok && (idx_ext != '0))
				fb_q[HW'(idx_ext - IXW'(1))] <= req_coef_q;
		end
	end

	// Histories and running correction sum. Entry k holds history index k before the shift.
	logic signed [HIST_W-1:0] in_hist_q  [FILTER_ORDER];
	logic signed [HIST_W-1:0] out_hist_q [FILTER_ORDER];
	logic signed [HIST_W-1:0] csum_q;
	logic signed [HIST_W-1:0] u_q;
	logic signed [HIST_W-1:0] y_q;
	logic signed [HIST_W-1:0] uin_q;
	logic signed [SAMP_W-1:0] q_q;

	// Uncorrected input: sample in Q16.32 plus the correction sum, saturated.
	logic signed [HIST_W:0] uin_w;
	assign uin_w = {req_sample_q[SAMP_W-1], req_sample_q, 16'd0} + {csum_q[HIST_W-1], csum_q};

	// Correction sum update with the emitted value.
	logic signed [HIST_W:0] cs_w;
	assign cs_w = {csum_q[HIST_W-1], csum_q} + {correction[SAMP_W-1], correction, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FILTER_ORDER; k++) begin
				in_hist_q[k]  <= '0;
				out_hist_q[k] <= '0;
			end
			csum_q <= '0;
		end else if (cmd.clr) begin
			for (int k = 0; k < FILTER_ORDER; k++) begin
				in_hist_q[k]  <= '0;
				out_hist_q[k] <= '0;
			end
			csum_q <= '0;
		end else begin
			if (cmd.diff) begin
				for (int k = 1; k < FILTER_ORDER; k++) begin
					in_hist_q[k]  <= in_hist_q[k-1];
					out_hist_q[k] <= out_hist_q[k-1];
				end
				in_hist_q[0]  <= u_q;
				out_hist_q[0] <= y_q;
			end
			if (cmd.update) begin
				if (cs_w[HIST_W] != cs_w[HIST_W-1])
					csum_q <= cs_w[HIST_W] ? MIN48 : MAX48;
				else
					csum_q <= cs_w[HIST_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_uin) begin
			if (uin_w[HIST_W] != uin_w[HIST_W-1])
				uin_q <= uin_w[HIST_W] ? MIN48 : MAX48;
			else
				uin_q <= uin_w[HIST_W-1:0];
		end
	end

	// Operand selection and partial-product multiply.
	logic [HW-1:0]             hidx;
	logic signed [HIST_W-1:0]  a_op;
	logic signed [MUL_B_W-1:0] b_op;
	logic signed [MUL_A_W-1:0] ma;
	logic signed [PP_W-1:0]    pp;

	assign hidx = HW'(tap - TW'(1));

	always_comb begin
		unique case (cmd.a_sel)
			A_UIN:      a_op = uin_q;
			A_IN_HIST:  a_op = in_hist_q[hidx];
			A_OUT_HIST: a_op = out_hist_q[hidx];
			A_U:        a_op = u_q;
			default:    a_op = u_q;
		endcase
		unique case (cmd.b_sel)
			B_GAIN:  b_op = {1'b0, inv_gain_q};
			B_FF:    b_op = {ff_q[tap][COEF_W-1], ff_q[tap]};
			B_FB:    b_op = {fb_q[hidx][COEF_W-1], fb_q[hidx]};
			default: b_op = {1'b0, inv_gain_q};
		endcase
	end

	assign ma = cmd.mac_hi ? {a_op[HIST_W-1], a_op[HIST_W-1:LO_W]} : {1'b0, a_op[LO_W-1:0]};
	assign pp = ma * b_op;

	// Stage 1: partial product.
	pipe_tag_t              tag_s1;
	logic signed [PP_W-1:0] pp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s1 <= '0;
		else
			tag_s1 <= '{vld: cmd.mac_vld, hi: cmd.mac_hi, gain: (cmd.b_sel == B_GAIN)};
	end

	always_ff @(posedge clk) begin
		pp_s1 <= pp;
	end

	// Stage 2: join both halves and add the rounding bias.
	logic signed [PP_W-1:0]   lo_q;
	logic signed [FULL_W-1:0] hi_ext;
	logic signed [FULL_W-1:0] lo_ext;
	logic signed [FULL_W-1:0] rnd;
	pipe_tag_t                tag_s2;
	logic signed [FULL_W-1:0] full_s2;

	assign hi_ext = {{(FULL_W-PP_W){pp_s1[PP_W-1]}}, pp_s1};
	assign lo_ext = {{(FULL_W-PP_W){lo_q[PP_W-1]}}, lo_q};
	assign rnd    = tag_s1.gain ? (FULL_W'(1) <<< (GAIN_SHIFT - 1))
	                            : (FULL_W'(1) <<< (COEF_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s2 <= '0;
		else
			tag_s2 <= '{vld: tag_s1.vld && tag_s1.hi, hi: 1'b1, gain: tag_s1.gain};
	end

	always_ff @(posedge clk) begin
		if (tag_s1.vld && !tag_s1.hi)
			lo_q <= pp_s1;
		full_s2 <= (hi_ext <<< LO_W) + lo_ext + rnd;
	end

	// Stage 3: scale back to Q16.32 and saturate.
	logic signed [FULL_W-1:0] sh;
	logic                     sh_ovf;
	pipe_tag_t                tag_s3;
	logic signed [HIST_W-1:0] rp_s3;

	assign sh     = tag_s2.gain ? (full_s2 >>> GAIN_SHIFT) : (full_s2 >>> COEF_SHIFT);
	assign sh_ovf = !((&sh[FULL_W-1:HIST_W-1]) || !(|sh[FULL_W-1:HIST_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s3 <= '0;
		else
			tag_s3 <= tag_s2;
	end

	always_ff @(posedge clk) begin
		if (sh_ovf)
			rp_s3 <= sh[FULL_W-1] ? MIN48 : MAX48;
		else
			rp_s3 <= sh[HIST_W-1:0];
	end

	// Stage 4: scaled input or filter accumulation.
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.load_uin)
			acc_q <= '0;
		else if (tag_s3.vld && !tag_s3.gain)
			acc_q <= acc_q + {{(ACC_W-HIST_W){rp_s3[HIST_W-1]}}, rp_s3};
		if (tag_s3.vld && tag_s3.gain)
			u_q <= rp_s3;
	end

	// Filter output, rounded difference and deadband.
	logic                     acc_ovf;
	logic signed [HIST_W+1:0] t_w;
	logic signed [SAMP_W+1:0] qf;
	logic [SAMP_W:0]          mag;
	logic                     supp;

	assign acc_ovf = !((&acc_q[ACC_W-1:HIST_W-1]) || !(|acc_q[ACC_W-1:HIST_W-1]));
	assign t_w = {{2{y_q[HIST_W-1]}}, y_q} - {{2{csum_q[HIST_W-1]}}, csum_q}
	           + (HIST_W+2)'(32768);
	assign qf  = t_w[HIST_W+1:16];
	assign mag = q_q[SAMP_W-1] ? ((SAMP_W+1)'(0) - {q_q[SAMP_W-1], q_q}) : {1'b0, q_q};
	assign supp = mag < (SAMP_W+1)'(min_move_q);

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			if (acc_ovf)
				y_q <= acc_q[ACC_W-1] ? MIN48 : MAX48;
			else
				y_q <= acc_q[HIST_W-1:0];
		end
		if (cmd.diff) begin
			if (!((&qf[SAMP_W+1:SAMP_W-1]) || !(|qf[SAMP_W+1:SAMP_W-1])))
				q_q <= qf[SAMP_W+1] ? {1'b1, {(SAMP_W-1){1'b0}}} : {1'b0, {(SAMP_W-1){1'b1}}};
			else
				q_q <= qf[SAMP_W-1:0];
		end
	end

	// Output register.
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.emit)
			out_vld_q <= 1'b1;
		else if (!out_stall)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			correction <= supp ? '0 : q_q;
			suppressed <= supp;
		end
	end

	assign out_valid      = out_vld_q;
	assign stat.req_cmd   = req_cmd_q;
	assign stat.pipe_busy = tag_s1.vld || tag_s2.vld || tag_s3.vld;
	assign stat.out_free  = !out_vld_q || !out_stall;

endmodule

[sv/idcf_ctrl.sv]
// Controller: sequences command decode, the multiply-accumulate passes and result delivery.
module idcf_ctrl #(
	parameter int FILTER_ORDER = idcf_pkg::FILTER_ORDER_DEF,
	parameter int TW = $clog2(FILTER_ORDER + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  idcf_pkg::dp_status_t stat,
	output idcf_pkg::ctrl_cmd_t  cmd,
	output logic [TW-1:0]        tap
);
	import idcf_pkg::*;

	localparam logic [TW-1:0] TAP_LAST = TW'(FILTER_ORDER);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_GAIN,
		S_FF,
		S_FB,
		S_FF0,
		S_DRAIN,
		S_SUM,
		S_DIFF,
		S_EMIT,
		S_UPDATE
	} state_t;

	state_t        state_q;
	logic          stall_q;
	logic          half_q;
	logic [TW-1:0] tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
			half_q  <= 1'b0;
			tap_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !stall_q) begin
						state_q <= S_DECODE;
						stall_q <= 1'b1;
					end
				end
				S_DECODE: begin
					half_q <= 1'b0;
					if (stat.req_cmd == CMD_FILTER) begin
						state_q <= S_GAIN;
					end else begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				S_GAIN: begin
					half_q <= ~half_q;
					if (half_q) begin
						state_q <= S_FF;
						tap_q   <= TW'(1);
					end
				end
				S_FF: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (tap_q == TAP_LAST) begin
							state_q <= S_FB;
							tap_q   <= TW'(1);
						end else begin
							tap_q <= tap_q + TW'(1);
						end
					end
				end
				S_FB: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (tap_q == TAP_LAST) begin
							state_q <= S_FF0;
							tap_q   <= '0;
						end else begin
							tap_q <= tap_q + TW'(1);
						end
					end
				end
				S_FF0: begin
					half_q <= ~half_q;
					if (half_q)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!stat.pipe_busy)
						state_q <= S_SUM;
				end
				S_SUM:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free)
						state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.a_sel = A_UIN;
		cmd.b_sel = B_GAIN;
		cmd.take  = (state_q == S_IDLE) && in_valid && !stall_q;
		unique case (state_q)
			S_DECODE: begin
				unique case (stat.req_cmd)
					CMD_FILTER:  cmd.load_uin = 1'b1;
					CMD_LOAD_FF: cmd.ld_ff    = 1'b1;
					CMD_LOAD_FB: cmd.ld_fb    = 1'b1;
					CMD_CLEAR:   cmd.clr      = 1'b1;
					default: ;
				endcase
			end
			S_GAIN: begin
				cmd.mac_vld = 1'b1;
				cmd.mac_hi  = half_q;
			end
			S_FF: begin
				cmd.mac_vld = 1'b1;
				cmd.mac_hi  = half_q;
				cmd.a_sel   = A_IN_HIST;
				cmd.b_sel   = B_FF;
			end
			S_FB: begin
				cmd.mac_vld = 1'b1;
				cmd.mac_hi  = half_q;
				cmd.a_sel   = A_OUT_HIST;
				cmd.b_sel   = B_FB;
			end
			S_FF0: begin
				cmd.mac_vld = 1'b1;
				cmd.mac_hi  = half_q;
				cmd.a_sel   = A_U;
				cmd.b_sel   = B_FF;
			end
			S_SUM:    cmd.sum    = 1'b1;
			S_DIFF:   cmd.diff   = 1'b1;
			S_EMIT:   cmd.emit   = stat.out_free;
			S_UPDATE: cmd.update = 1'b1;
			default: ;
		endcase
	end

	assign in_stall = stall_q;
	assign tap      = tap_q;

endmodule

[sv/idcf_checker.sv]
// Port-level checks for the deadband correction filter and their binding to the top level.
module idcf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] correction,
	input logic               suppressed
);

	// A result waiting at the output stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A waiting result does not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(correction) && $stable(suppressed))
		else $error("stalled result changed");

	// A suppressed correction is always zero.
	a_supp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && suppressed |-> correction == 32'sd0)
		else $error("suppressed result carries a nonzero correction");

	// The block works on one request at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted back to back");

endmodule

bind iir_deadband_correction_filter idcf_checker u_idcf_checker (.*);
